### hw/rtl/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Types, operation codes and constants shared by the time arithmetic pipeline.
// ----------------------------------------------------------------------------
package pta_pkg;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_HALVE = 3'd2;
   localparam logic [2:0] OP_CORR  = 3'd3;
   localparam logic [2:0] OP_FLAT  = 3'd4;

   localparam logic signed [30:0] NS_PER_SEC_S = 31'sd1000000000;
   localparam logic signed [31:0] NS_PER_SEC_W = 32'sd1000000000;
   localparam logic signed [31:0] HALF_SEC_NS  = 32'sd500000000;
   localparam logic [29:0]        NS_PER_SEC_U = 30'd1000000000;

   // thresholds for the small quotient of a 33-bit nanosecond magnitude
   localparam logic [32:0] NS_X1 = 33'd1000000000;
   localparam logic [32:0] NS_X2 = 33'd2000000000;
   localparam logic [32:0] NS_X3 = 33'd3000000000;
   localparam logic [32:0] NS_X4 = 33'd4000000000;

   // floor(2^49 / 10^9): quotient estimate is (mag >> 17) * RECIP_NS >> 32
   localparam logic [19:0] RECIP_NS = 20'd562949;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] seconds_a;
      logic signed [31:0] nanos_a;
      logic signed [31:0] seconds_b;
      logic signed [31:0] nanos_b;
      logic signed [63:0] correction;
   } pta_req_type;

   typedef struct packed {
      logic signed [31:0] result_seconds;
      logic signed [31:0] result_nanos;
      logic signed [63:0] total_nanos;
   } pta_rsp_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [31:0]        secs;
      logic signed [32:0] nanos;
      logic [47:0]        mag;
      logic               neg;
      logic signed [62:0] prod;
   } pta_s1_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [31:0]        secs;
      logic signed [3:0]  q;
      logic signed [31:0] nanos;
      logic signed [63:0] total;
      logic [47:0]        mag;
      logic               neg;
      logic [50:0]        cprod;
   } pta_s2_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [31:0]        secs;
      logic signed [31:0] nanos;
      logic signed [63:0] total;
      logic [47:0]        mag;
      logic               neg;
      logic [17:0]        qe;
      logic [47:0]        qp;
   } pta_s3_type;

endpackage

### hw/rtl/ptp_time_arith_unit.sv
// ----------------------------------------------------------------------------
// ptp_time_arith_unit
// Seconds/nanoseconds time arithmetic for timestamp processing.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start; the item is taken at any rising edge with
//   start high and busy low. busy is always low, so a new item may be issued
//   every cycle.
//   Operations: add, subtract, halve time a, correction field to time, and
//   time a to total nanoseconds.
//   Each item gives one result on rsp_item, marked by rsp_valid for one cycle.
//   The item passes four register stages (sums and products, small quotient
//   and reciprocal product, carry and back-multiply, remainder fix and
//   select) before the strobe. Throughput is one item per cycle; the
//   receiver cannot stall, so the pipeline advances every cycle and
//   results leave in issue order.
//   Synchronous reset clears all stage valid bits; items in flight are
//   dropped and no strobe appears until new items arrive.
// ----------------------------------------------------------------------------
module ptp_time_arith_unit import pta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  pta_req_type req_item,
   output logic        rsp_valid,
   output pta_rsp_type rsp_item
);

   logic       in_valid;
   logic       s1_valid;
   logic       s2_valid;
   logic       s3_valid;
   pta_s1_type s1_item;
   pta_s2_type s2_item;
   pta_s3_type s3_item;

   assign busy     = 1'b0;
   assign in_valid = start && !busy;

   pta_stage_in u_stage_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .req_item (req_item),
      .s1_valid (s1_valid),
      .s1_item  (s1_item)
   );

   pta_stage_div u_stage_div (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_item  (s1_item),
      .s2_valid (s2_valid),
      .s2_item  (s2_item)
   );

   pta_stage_norm u_stage_norm (
      .clock    (clock),
      .reset    (reset),
      .s2_valid (s2_valid),
      .s2_item  (s2_item),
      .s3_valid (s3_valid),
      .s3_item  (s3_item)
   );

   pta_stage_out u_stage_out (
      .clock     (clock),
      .reset     (reset),
      .s3_valid  (s3_valid),
      .s3_item   (s3_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### hw/rtl/pta_stage_in.sv
// ----------------------------------------------------------------------------
// pta_stage_in
// First stage: operand sums, halving, correction magnitude, seconds product.
// ----------------------------------------------------------------------------
module pta_stage_in import pta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  pta_req_type req_item,
   output logic        s1_valid,
   output pta_s1_type  s1_item
);

   logic               valid_ff;
   pta_s1_type         item_ff;
   pta_s1_type         item_in;
   logic signed [32:0] sec_x;
   logic signed [32:0] ns_x;
   logic signed [32:0] sec_h;
   logic signed [32:0] ns_h;
   logic signed [31:0] half_ns;
   logic [63:0]        corr_abs;

   always_comb begin
      // truncating divide by two: bias negatives by one before the shift
      sec_x = 33'(req_item.seconds_a) + $signed({32'd0, req_item.seconds_a[31]});
      ns_x  = 33'(req_item.nanos_a) + $signed({32'd0, req_item.nanos_a[31]});
      sec_h = sec_x >>> 1;
      ns_h  = ns_x >>> 1;
      half_ns = ns_h[31:0];
      if (req_item.seconds_a[0]) begin
         if (req_item.seconds_a[31]) begin
            half_ns = ns_h[31:0] - HALF_SEC_NS;
         end else begin
            half_ns = ns_h[31:0] + HALF_SEC_NS;
         end
      end
      corr_abs = req_item.correction[63] ? 64'(-req_item.correction)
                                         : 64'(req_item.correction);
   end

   always_comb begin
      item_in    = '0;
      item_in.op = req_item.operation;
      case (req_item.operation)
         OP_ADD: begin
            item_in.secs  = req_item.seconds_a + req_item.seconds_b;
            item_in.nanos = 33'(req_item.nanos_a) + 33'(req_item.nanos_b);
         end
         OP_SUB: begin
            item_in.secs  = req_item.seconds_a - req_item.seconds_b;
            item_in.nanos = 33'(req_item.nanos_a) - 33'(req_item.nanos_b);
         end
         OP_HALVE: begin
            item_in.secs  = sec_h[31:0];
            item_in.nanos = 33'(half_ns);
         end
         OP_CORR: begin
            item_in.mag = corr_abs[63:16];
            item_in.neg = req_item.correction[63];
         end
         OP_FLAT: begin
            item_in.nanos = 33'(req_item.nanos_a);
            item_in.prod  = 63'(req_item.seconds_a) * 63'(NS_PER_SEC_S);
         end
         default: begin
            item_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;

endmodule

### hw/rtl/pta_stage_div.sv
// ----------------------------------------------------------------------------
// pta_stage_div
// Second stage: small quotient of the nanosecond sum, reciprocal product for
// the correction quotient, total nanoseconds sum.
// ----------------------------------------------------------------------------
module pta_stage_div import pta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       s1_valid,
   input  pta_s1_type s1_item,
   output logic       s2_valid,
   output pta_s2_type s2_item
);

   logic       valid_ff;
   pta_s2_type item_ff;
   pta_s2_type item_in;
   logic [32:0] n_mag;
   logic [32:0] n_sub;
   logic [2:0]  q_mag;
   logic [32:0] r_mag;

   always_comb begin
      n_mag = s1_item.nanos[32] ? 33'(-s1_item.nanos) : 33'(s1_item.nanos);
      if (n_mag >= NS_X4) begin
         q_mag = 3'd4;
         n_sub = NS_X4;
      end else if (n_mag >= NS_X3) begin
         q_mag = 3'd3;
         n_sub = NS_X3;
      end else if (n_mag >= NS_X2) begin
         q_mag = 3'd2;
         n_sub = NS_X2;
      end else if (n_mag >= NS_X1) begin
         q_mag = 3'd1;
         n_sub = NS_X1;
      end else begin
         q_mag = 3'd0;
         n_sub = '0;
      end
      r_mag = n_mag - n_sub;
   end

   always_comb begin
      item_in       = '0;
      item_in.op    = s1_item.op;
      item_in.secs  = s1_item.secs;
      item_in.nanos = s1_item.nanos[31:0];
      item_in.mag   = s1_item.mag;
      item_in.neg   = s1_item.neg;
      case (s1_item.op)
         OP_ADD, OP_SUB: begin
            if (s1_item.nanos[32]) begin
               item_in.q     = -$signed({1'b0, q_mag});
               item_in.nanos = -$signed(r_mag[31:0]);
            end else begin
               item_in.q     = $signed({1'b0, q_mag});
               item_in.nanos = $signed(r_mag[31:0]);
            end
         end
         OP_CORR: begin
            item_in.cprod = 51'(s1_item.mag[47:17]) * 51'(RECIP_NS);
         end
         OP_FLAT: begin
            item_in.total = 64'(s1_item.prod) + 64'(s1_item.nanos);
         end
         default: begin
            item_in.q = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign s2_valid = valid_ff;
   assign s2_item  = item_ff;

endmodule

### hw/rtl/pta_stage_norm.sv
// ----------------------------------------------------------------------------
// pta_stage_norm
// Third stage: seconds carry and sign fix for add/subtract, back-multiply of
// the correction quotient estimate.
// ----------------------------------------------------------------------------
module pta_stage_norm import pta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       s2_valid,
   input  pta_s2_type s2_item,
   output logic       s3_valid,
   output pta_s3_type s3_item
);

   logic       valid_ff;
   pta_s3_type item_ff;
   pta_s3_type item_in;
   logic [31:0] sum0;
   logic        s_pos;
   logic        s_neg;
   logic        n_pos;
   logic        n_neg;

   always_comb begin
      sum0  = s2_item.secs + 32'(s2_item.q);
      s_neg = sum0[31];
      s_pos = !sum0[31] && (sum0 != '0);
      n_neg = s2_item.nanos[31];
      n_pos = !s2_item.nanos[31] && (s2_item.nanos != '0);
   end

   always_comb begin
      item_in       = '0;
      item_in.op    = s2_item.op;
      item_in.secs  = s2_item.secs;
      item_in.nanos = s2_item.nanos;
      item_in.total = s2_item.total;
      item_in.mag   = s2_item.mag;
      item_in.neg   = s2_item.neg;
      item_in.qe    = s2_item.cprod[49:32];
      item_in.qp    = 48'(s2_item.cprod[49:32]) * 48'(NS_PER_SEC_U);
      case (s2_item.op)
         OP_ADD, OP_SUB: begin
            // borrow or return one second when seconds and nanos disagree
            if (s_pos && n_neg) begin
               item_in.secs  = sum0 - 32'd1;
               item_in.nanos = s2_item.nanos + NS_PER_SEC_W;
            end else if (s_neg && n_pos) begin
               item_in.secs  = sum0 + 32'd1;
               item_in.nanos = s2_item.nanos - NS_PER_SEC_W;
            end else begin
               item_in.secs = sum0;
            end
         end
         default: begin
            item_in.op = s2_item.op;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign s3_valid = valid_ff;
   assign s3_item  = item_ff;

endmodule

### hw/rtl/pta_stage_out.sv
// ----------------------------------------------------------------------------
// pta_stage_out
// Last stage: correction remainder fix-up and sign, result select per
// operation, result register and strobe.
// ----------------------------------------------------------------------------
module pta_stage_out import pta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        s3_valid,
   input  pta_s3_type  s3_item,
   output logic        rsp_valid,
   output pta_rsp_type rsp_item
);

   logic        valid_ff;
   pta_rsp_type item_ff;
   pta_rsp_type item_in;
   logic [47:0] r_full;
   logic [30:0] r_fix;
   logic [17:0] q_fix;

   always_comb begin
      // quotient estimate is low by at most one
      r_full = s3_item.mag - s3_item.qp;
      if (r_full[30:0] >= 31'(NS_PER_SEC_U)) begin
         r_fix = r_full[30:0] - 31'(NS_PER_SEC_U);
         q_fix = s3_item.qe + 18'd1;
      end else begin
         r_fix = r_full[30:0];
         q_fix = s3_item.qe;
      end
   end

   always_comb begin
      item_in = '0;
      case (s3_item.op)
         OP_ADD, OP_SUB, OP_HALVE: begin
            item_in.result_seconds = s3_item.secs;
            item_in.result_nanos   = s3_item.nanos;
         end
         OP_CORR: begin
            if (s3_item.neg) begin
               item_in.result_seconds = -$signed(32'(q_fix));
               item_in.result_nanos   = -$signed(32'(r_fix));
            end else begin
               item_in.result_seconds = $signed(32'(q_fix));
               item_in.result_nanos   = $signed(32'(r_fix));
            end
         end
         OP_FLAT: begin
            item_in.total_nanos = s3_item.total;
         end
         default: begin
            item_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

### bench/ptp_time_arith_unit_tb.sv
// ----------------------------------------------------------------------------
// ptp_time_arith_unit_tb
// Self-checking bench for the PTP time arithmetic unit. Directed corner items
// for add, subtract, halve, correction and flatten (plus the unused opcodes)
// are followed by random items with bursty and sparse issue. Every result is
// checked field by field against an in-bench computation of the time math.
// ----------------------------------------------------------------------------
module ptp_time_arith_unit_tb;
   import pta_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   localparam longint NS_IN_SEC = 1000000000;
   localparam longint HALF_SEC  = 500000000;
   localparam longint CORR_UNIT = 65536;

   localparam int RANDOM_BATCHES = 11;
   localparam int BATCH_ITEMS    = 100;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   pta_req_type req_item;
   logic        rsp_valid;
   pta_rsp_type rsp_item;

   pta_req_type op_queue[$];
   pta_rsp_type time_results_q[$];

   int items_queued    = 0;
   int items_launched  = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int gap_max         = 17;
   int gap_left        = 0;
   int op_count[8];

   ptp_time_arith_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // time arithmetic, worked in 64-bit signed integers
   function automatic pta_rsp_type predict_time_result(input pta_req_type it);
      pta_rsp_type r;
      longint      sa, na, sb, nb, corr, n, q, e;
      logic [31:0] s;
      r    = '0;
      sa   = $signed(it.seconds_a);
      na   = $signed(it.nanos_a);
      sb   = $signed(it.seconds_b);
      nb   = $signed(it.nanos_b);
      corr = $signed(it.correction);
      case (it.operation)
         OP_ADD, OP_SUB: begin
            if (it.operation == OP_ADD) begin
               s = it.seconds_a + it.seconds_b;
               n = na + nb;
            end else begin
               s = it.seconds_a - it.seconds_b;
               n = na - nb;
            end
            q = n / NS_IN_SEC;
            s = s + q[31:0];
            n = n - q * NS_IN_SEC;
            // seconds and nanoseconds must agree in sign
            if ($signed(s) > 0 && n < 0) begin
               s = s - 32'd1;
               n = n + NS_IN_SEC;
            end else if ($signed(s) < 0 && n > 0) begin
               s = s + 32'd1;
               n = n - NS_IN_SEC;
            end
            r.result_seconds = s;
            r.result_nanos   = n[31:0];
         end
         OP_HALVE: begin
            n = na / 2;
            q = sa / 2;
            if (sa[0]) begin
               if (sa > 0) n = n + HALF_SEC;
               else        n = n - HALF_SEC;
            end
            r.result_seconds = q[31:0];
            r.result_nanos   = n[31:0];
         end
         OP_CORR: begin
            e = corr / CORR_UNIT;
            q = e / NS_IN_SEC;
            n = e - q * NS_IN_SEC;
            r.result_seconds = q[31:0];
            r.result_nanos   = n[31:0];
         end
         OP_FLAT: begin
            r.total_nanos = sa * NS_IN_SEC + na;
         end
         default: begin
            r = '0;
         end
      endcase
      return r;
   endfunction

   // ---- driver: issues queued items, random gap after each one ----
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || items_accepted == items_launched) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (op_queue.size() > 0) begin
            req_item <= op_queue.pop_front();
            start <= 1'b1;
            items_launched = items_launched + 1;
            gap_left = $urandom_range(0, gap_max);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---- monitor: records accepted items, checks each result strobe ----
   always @(posedge clock) begin
      pta_rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            time_results_q.push_back(predict_time_result(req_item));
            op_count[req_item.operation] = op_count[req_item.operation] + 1;
            items_accepted = items_accepted + 1;
         end
         if (rsp_valid) begin
            if (time_results_q.size() == 0) begin
               $error("result strobe with no item outstanding");
               mismatch_count = mismatch_count + 1;
            end else begin
               want = time_results_q.pop_front();
               results_checked = results_checked + 1;
               if (rsp_item.result_seconds !== want.result_seconds) begin
                  $error("result_seconds: expected %0d, got %0d",
                         want.result_seconds, rsp_item.result_seconds);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_item.result_nanos !== want.result_nanos) begin
                  $error("result_nanos: expected %0d, got %0d",
                         want.result_nanos, rsp_item.result_nanos);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_item.total_nanos !== want.total_nanos) begin
                  $error("total_nanos: expected %0d, got %0d",
                         want.total_nanos, rsp_item.total_nanos);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
   end

   task automatic queue_op(input logic [2:0] op, input logic [31:0] sa,
                           input logic [31:0] na, input logic [31:0] sb,
                           input logic [31:0] nb, input logic [63:0] corr);
      pta_req_type it;
      it.operation  = op;
      it.seconds_a  = sa;
      it.nanos_a    = na;
      it.seconds_b  = sb;
      it.nanos_b    = nb;
      it.correction = corr;
      op_queue.push_back(it);
      items_queued = items_queued + 1;
   endtask

   // block until every queued item is taken and every result has come back
   task automatic wait_drained();
      while (items_accepted != items_queued || time_results_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [31:0] pick_seconds();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return int'($urandom_range(0, 2000)) - 1000;
         3: return int'($urandom_range(0, 200000000)) - 100000000;
         default: begin
            case ($urandom_range(0, 5))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'hffff_ffff;
               3: return 32'd1;
               4: return 32'h7fff_fffe;
               default: return 32'd0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_nanos();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2, 3: return int'($urandom_range(0, 1999999998)) - 999999999;
         default: begin
            case ($urandom_range(0, 7))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'd999999999;
               3: return -32'sd999999999;
               4: return 32'd1000000000;
               5: return -32'sd1000000000;
               6: return 32'hffff_ffff;
               default: return 32'd0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [63:0] pick_correction();
      longint v;
      case ($urandom_range(0, 4))
         0, 1: return {$urandom, $urandom};
         // whole nanoseconds with a random fraction, a few seconds either way
         2: begin
            v = longint'(int'($urandom_range(0, 20000000)) - 10000000) * 1000;
            return v * CORR_UNIT + longint'($urandom_range(0, 65535));
         end
         3: return longint'(int'($urandom)) * CORR_UNIT;
         default: begin
            case ($urandom_range(0, 4))
               0: return 64'h7fff_ffff_ffff_ffff;
               1: return 64'h8000_0000_0000_0000;
               2: return 64'hffff_ffff_ffff_ffff;
               3: return -64'sd65536;
               default: return 64'd0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [2:0] pick_op();
      if ($urandom_range(0, 19) == 0) begin
         case ($urandom_range(0, 2))
            0: return OP_RSVD5;
            1: return OP_RSVD6;
            default: return OP_RSVD7;
         endcase
      end
      case ($urandom_range(0, 4))
         0: return OP_ADD;
         1: return OP_SUB;
         2: return OP_HALVE;
         3: return OP_CORR;
         default: return OP_FLAT;
      endcase
   endfunction

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners
      gap_max = 3;
      queue_op(OP_ADD, 32'd1, 32'd999999999, 32'd2, 32'd999999999, 64'd0);
      queue_op(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               64'd0);
      queue_op(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               64'd0);
      queue_op(OP_ADD, 32'd5, -32'sd300, 32'd0, 32'd0, 64'd0);      // borrow
      queue_op(OP_ADD, -32'sd5, 32'd300, 32'd0, 32'd0, 64'd0);      // return a second
      queue_op(OP_ADD, 32'd0, -32'sd999999999, 32'd0, -32'sd1, 64'd0);
      queue_op(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
               64'd0);
      queue_op(OP_SUB, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
               64'd0);
      queue_op(OP_SUB, 32'd3, 32'd100, 32'd1, 32'd200, 64'd0);
      queue_op(OP_SUB, 32'd0, 32'd0, 32'd0, 32'd1, 64'd0);
      queue_op(OP_HALVE, 32'd7, 32'd3, 32'd0, 32'd0, 64'd0);         // odd positive
      queue_op(OP_HALVE, -32'sd7, -32'sd3, 32'd0, 32'd0, 64'd0);     // odd negative
      queue_op(OP_HALVE, 32'd0, -32'sd1, 32'd0, 32'd0, 64'd0);       // zero seconds
      queue_op(OP_HALVE, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 32'd0, 64'd0);
      queue_op(OP_HALVE, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 64'd0);
      queue_op(OP_CORR, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0);
      queue_op(OP_CORR, 32'd0, 32'd0, 32'd0, 32'd0, 64'h7fff_ffff_ffff_ffff);
      queue_op(OP_CORR, 32'd0, 32'd0, 32'd0, 32'd0, 64'h8000_0000_0000_0000);
      queue_op(OP_CORR, 32'd0, 32'd0, 32'd0, 32'd0, 64'hffff_ffff_ffff_ffff);
      queue_op(OP_CORR, 32'd0, 32'd0, 32'd0, 32'd0, -64'sd65537000000000);
      queue_op(OP_FLAT, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 32'd0, 64'd0);
      queue_op(OP_FLAT, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 64'd0);
      queue_op(OP_RSVD5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
               64'hffff_ffff_ffff_ffff);
      queue_op(OP_RSVD6, 32'd1, 32'd1, 32'd1, 32'd1, 64'd1);
      queue_op(OP_RSVD7, 32'h8000_0000, 32'd5, 32'd6, 32'd7, 64'd8);
      wait_drained();

      for (int b = 0; b < RANDOM_BATCHES; b++) begin
         // back-to-back bursts every third batch, sparse issue otherwise
         gap_max = (b % 3 == 0) ? 0 : 17;
         for (int i = 0; i < BATCH_ITEMS; i++)
            queue_op(pick_op(), pick_seconds(), pick_nanos(), pick_seconds(),
                     pick_nanos(), pick_correction());
         while (op_queue.size() != 0) @(posedge clock);
         if (b == RANDOM_BATCHES / 2) wait_drained();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d items: add %0d, sub %0d, halve %0d, corr %0d, flat %0d,",
               items_accepted, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_HALVE],
               op_count[OP_CORR], op_count[OP_FLAT]);
      $display("unused opcodes %0d; %0d results checked, %0d mismatches",
               op_count[OP_RSVD5] + op_count[OP_RSVD6] + op_count[OP_RSVD7],
               results_checked, mismatch_count);
      if (mismatch_count == 0 && time_results_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (time_results_q.size() != 0)
            $error("%0d results never arrived", time_results_q.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #3ms;
      $error("run did not complete in time");
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### ptp_time_arith_unit.f
hw/rtl/pta_pkg.sv
hw/rtl/pta_stage_in.sv
hw/rtl/pta_stage_div.sv
hw/rtl/pta_stage_norm.sv
hw/rtl/pta_stage_out.sv
hw/rtl/ptp_time_arith_unit.sv
bench/ptp_time_arith_unit_tb.sv
